// File: sv/pmba_pkg.sv
// types and constants shared by the protected memory bus access block
package pmba_pkg;

  typedef enum logic [1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_FETCH   = 2'd2,
    FUNC_PRELOAD = 2'd3
  } func_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef enum logic [1:0] {
    AREA_ROM,
    AREA_RAM,
    AREA_MMIO
  } area_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_MEMORY    = 2'd1,
    FAULT_PRIVILEGE = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ROM,
    SRC_RAM,
    SRC_DEVICE
  } byte_src_t;

  // where one byte of read data comes from
  typedef struct packed {
    byte_src_t   src;
    logic [1:0]  bank;
    logic [7:0]  fixed;
  } lane_t;

  localparam logic [1:0] CFG_ROM_START = 2'd0;
  localparam logic [1:0] CFG_ROM_LAST  = 2'd1;
  localparam logic [1:0] CFG_RAM_START = 2'd2;
  localparam logic [1:0] CFG_RAM_LAST  = 2'd3;

  localparam logic [31:0] ROM_START_RESET = 32'd0;
  localparam logic [31:0] ROM_LAST_RESET  = 32'd16383;
  localparam logic [31:0] RAM_START_RESET = 32'd16384;
  localparam logic [31:0] RAM_LAST_RESET  = 32'd81919;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 136;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TUSER_W = 3;

endpackage

// File: sv/protected_memory_bus_access_top.sv
// protected memory bus access port with internal rom and ram
//
// Takes one access per cycle (read, write, fetch or preload byte) while the
// output is not held back by m_tready and no clearing pass runs, and returns
// one result word for each through an input register, the registered read of
// the byte-banked rom and ram arrays, and an output register. Each array is
// split into four byte banks with one write and one read port, so an access of
// up to four bytes at any base offset completes in one pass. After reset a
// clearing pass zeroes both arrays, one row of all banks per cycle; no access
// is taken until it ends. The user must write the bound registers through the
// cfg port only while the block is idle; the block itself does not enforce it.
module protected_memory_bus_access_top #(
  parameter int ROM_BYTES = 16384,
  parameter int RAM_BYTES = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // access_size, address, supervisor, fault_pc, write_data, device_present,
  // device_word
  input  logic [pmba_pkg::IN_TDATA_W-1:0]     s_tdata,
  // func
  input  logic [pmba_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // fault_epc, read_data, mmio_read, mmio_write, mmio_address, mmio_data
  output logic [pmba_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // ok, fault_kind
  output logic [pmba_pkg::OUT_TUSER_W-1:0]    m_tuser
);

  localparam int ROM_ROWS = (ROM_BYTES + 3) / 4;
  localparam int RAM_ROWS = (RAM_BYTES + 3) / 4;
  localparam int ROM_AW   = (ROM_ROWS > 1) ? $clog2(ROM_ROWS) : 1;
  localparam int RAM_AW   = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;
  localparam int CLR_ROWS = (ROM_ROWS > RAM_ROWS) ? ROM_ROWS : RAM_ROWS;
  localparam int CW       = $clog2(CLR_ROWS + 1);

  // bound registers
  logic [31:0] rom_start, rom_last, ram_start, ram_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_start <= pmba_pkg::ROM_START_RESET;
      rom_last  <= pmba_pkg::ROM_LAST_RESET;
      ram_start <= pmba_pkg::RAM_START_RESET;
      ram_last  <= pmba_pkg::RAM_LAST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pmba_pkg::CFG_ROM_START: rom_start <= cfg_data;
        pmba_pkg::CFG_ROM_LAST:  rom_last  <= cfg_data;
        pmba_pkg::CFG_RAM_START: ram_start <= cfg_data;
        pmba_pkg::CFG_RAM_LAST:  ram_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_active;
  logic [CW-1:0] clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == CW'(CLR_ROWS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // pipeline flow control
  logic s1_valid, s2_valid, out_valid;
  logic adv_out, adv2, adv1;

  assign adv_out  = !out_valid || m_tready;
  assign adv2     = !s2_valid || adv_out;
  assign adv1     = !s1_valid || adv2;
  assign s_tready = adv1 && !clr_active;

  // input register
  pmba_pkg::func_t s1_func;
  logic [1:0]      s1_size;
  logic [31:0]     s1_addr;
  logic            s1_sup;
  logic [31:0]     s1_pc;
  logic [31:0]     s1_wd;
  logic            s1_present;
  logic [31:0]     s1_dword;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_func    <= pmba_pkg::func_t'(s_tuser[1:0]);
      s1_size    <= s_tdata[1:0];
      s1_addr    <= s_tdata[33:2];
      s1_sup     <= s_tdata[34];
      s1_pc      <= s_tdata[66:35];
      s1_wd      <= s_tdata[98:67];
      s1_present <= s_tdata[99];
      s1_dword   <= s_tdata[131:100];
    end
  end

  // decode, checks and bank addressing
  pmba_pkg::area_t      region [4];
  logic [3:0]           act;
  logic [31:0]          rom_off0, ram_off0;
  logic [31:0]          rom_off [4];
  logic [31:0]          ram_off [4];
  logic [3:0]           rom_in, ram_in, rom_wr, ram_wr;
  logic                 misaligned, do_read, do_write;
  pmba_pkg::fault_t     kind;
  pmba_pkg::lane_t      lane_c [4];
  logic [3:0]           mmio_act;
  logic                 any_mmio, did_read, did_write;
  logic [31:0]          merged;
  logic [31:0]          byte_addr;
  logic [1:0]           dlane;

  always_comb begin
    rom_off0 = s1_addr - rom_start;
    ram_off0 = s1_addr - ram_start;
    for (int k = 0; k < 4; k++) begin
      byte_addr = {s1_addr[31:2], s1_addr[1:0] | 2'(k)};
      if (byte_addr <= rom_last) begin
        region[k] = pmba_pkg::AREA_ROM;
      end else if (byte_addr <= ram_last) begin
        region[k] = pmba_pkg::AREA_RAM;
      end else begin
        region[k] = pmba_pkg::AREA_MMIO;
      end
      rom_off[k] = rom_off0 + 32'(k);
      ram_off[k] = ram_off0 + 32'(k);
      rom_in[k]  = rom_off[k] < 32'(ROM_BYTES);
      ram_in[k]  = ram_off[k] < 32'(RAM_BYTES);
    end

    if (s1_func == pmba_pkg::FUNC_FETCH) begin
      act = 4'b1111;
    end else if (s1_func == pmba_pkg::FUNC_PRELOAD || s1_size == pmba_pkg::SIZE_BYTE) begin
      act = 4'b0001;
    end else if (s1_size == pmba_pkg::SIZE_HALF) begin
      act = 4'b0011;
    end else begin
      act = 4'b1111;
    end

    misaligned = (s1_size == pmba_pkg::SIZE_HALF && s1_addr[0]) ||
                 (s1_size[1] && s1_addr[1:0] != 2'b00);

    kind = pmba_pkg::FAULT_NONE;
    case (s1_func)
      pmba_pkg::FUNC_READ: begin
        if (misaligned) begin
          kind = pmba_pkg::FAULT_MEMORY;
        end else if (region[0] == pmba_pkg::AREA_MMIO && !s1_sup) begin
          kind = pmba_pkg::FAULT_PRIVILEGE;
        end
      end
      pmba_pkg::FUNC_WRITE: begin
        if (misaligned || region[0] == pmba_pkg::AREA_ROM) begin
          kind = pmba_pkg::FAULT_MEMORY;
        end else if (region[0] == pmba_pkg::AREA_MMIO && !s1_sup) begin
          kind = pmba_pkg::FAULT_PRIVILEGE;
        end
      end
      pmba_pkg::FUNC_FETCH: begin
        if (s1_addr[1:0] != 2'b00 || region[0] == pmba_pkg::AREA_MMIO) begin
          kind = pmba_pkg::FAULT_MEMORY;
        end
      end
      default: kind = pmba_pkg::FAULT_NONE;
    endcase

    do_read  = kind == pmba_pkg::FAULT_NONE &&
               (s1_func == pmba_pkg::FUNC_READ || s1_func == pmba_pkg::FUNC_FETCH);
    do_write = kind == pmba_pkg::FAULT_NONE && s1_func == pmba_pkg::FUNC_WRITE;

    merged = s1_dword;
    for (int k = 0; k < 4; k++) begin
      dlane       = s1_addr[1:0] | 2'(k);
      mmio_act[k] = act[k] && region[k] == pmba_pkg::AREA_MMIO;
      rom_wr[k]   = s1_valid && adv2 && act[k] && s1_func == pmba_pkg::FUNC_PRELOAD &&
                    region[k] == pmba_pkg::AREA_ROM && rom_in[k];
      ram_wr[k]   = s1_valid && adv2 && act[k] &&
                    (do_write || s1_func == pmba_pkg::FUNC_PRELOAD) &&
                    region[k] == pmba_pkg::AREA_RAM && ram_in[k];
      lane_c[k].src   = pmba_pkg::SRC_ZERO;
      lane_c[k].bank  = 2'b00;
      lane_c[k].fixed = 8'h00;
      if (do_read && act[k]) begin
        case (region[k])
          pmba_pkg::AREA_ROM: begin
            if (rom_in[k]) begin
              lane_c[k].src  = pmba_pkg::SRC_ROM;
              lane_c[k].bank = rom_off[k][1:0];
            end
          end
          pmba_pkg::AREA_RAM: begin
            if (ram_in[k]) begin
              lane_c[k].src  = pmba_pkg::SRC_RAM;
              lane_c[k].bank = ram_off[k][1:0];
            end
          end
          default: begin
            if (s1_present) begin
              lane_c[k].src   = pmba_pkg::SRC_DEVICE;
              lane_c[k].fixed = s1_dword[{dlane, 3'b000} +: 8];
            end
          end
        endcase
      end
      if (mmio_act[k]) begin
        merged[{dlane, 3'b000} +: 8] = s1_wd[8*k +: 8];
      end
    end

    any_mmio  = |mmio_act && s1_present;
    did_write = do_write && any_mmio;
    // a full word store to a device replaces the word without reading it
    did_read  = (do_read && any_mmio) ||
                (did_write && !(s1_size[1] && region[0] == pmba_pkg::AREA_MMIO));
  end

  // byte banks
  logic [3:0]        rom_we, ram_we;
  logic [ROM_AW-1:0] rom_wa [4];
  logic [ROM_AW-1:0] rom_ra [4];
  logic [RAM_AW-1:0] ram_wa [4];
  logic [RAM_AW-1:0] ram_ra [4];
  logic [7:0]        rom_wd [4];
  logic [7:0]        ram_wd [4];
  logic [7:0]        rom_q  [4];
  logic [7:0]        ram_q  [4];
  logic [1:0]        rom_k, ram_k;
  logic              clr_rom, clr_ram;

  always_comb begin
    clr_rom = clr_active && clr_row < CW'(ROM_ROWS);
    clr_ram = clr_active && clr_row < CW'(RAM_ROWS);
    for (int r = 0; r < 4; r++) begin
      rom_k     = 2'(r) - rom_off0[1:0];
      ram_k     = 2'(r) - ram_off0[1:0];
      rom_ra[r] = rom_off[rom_k][ROM_AW+1:2];
      ram_ra[r] = ram_off[ram_k][RAM_AW+1:2];
      if (clr_active) begin
        rom_we[r] = clr_rom;
        rom_wa[r] = clr_row[ROM_AW-1:0];
        rom_wd[r] = 8'h00;
        ram_we[r] = clr_ram;
        ram_wa[r] = clr_row[RAM_AW-1:0];
        ram_wd[r] = 8'h00;
      end else begin
        rom_we[r] = rom_wr[rom_k];
        rom_wa[r] = rom_ra[r];
        rom_wd[r] = s1_wd[{rom_k, 3'b000} +: 8];
        ram_we[r] = ram_wr[ram_k];
        ram_wa[r] = ram_ra[r];
        ram_wd[r] = s1_wd[{ram_k, 3'b000} +: 8];
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_bank
    logic [7:0] rom_mem [ROM_ROWS];
    logic [7:0] ram_mem [RAM_ROWS];

    always_ff @(posedge clk) begin
      if (rom_we[r]) begin
        rom_mem[rom_wa[r]] <= rom_wd[r];
      end
      if (adv2) begin
        rom_q[r] <= rom_mem[rom_ra[r]];
      end
    end

    always_ff @(posedge clk) begin
      if (ram_we[r]) begin
        ram_mem[ram_wa[r]] <= ram_wd[r];
      end
      if (adv2) begin
        ram_q[r] <= ram_mem[ram_ra[r]];
      end
    end
  end

  // second stage
  pmba_pkg::fault_t s2_kind;
  logic [31:0]      s2_pc;
  pmba_pkg::lane_t  s2_lane [4];
  logic             s2_mread, s2_mwrite;
  logic [31:0]      s2_maddr, s2_mdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_kind   <= kind;
      s2_pc     <= (kind != pmba_pkg::FAULT_NONE) ? s1_pc : 32'd0;
      s2_lane   <= lane_c;
      s2_mread  <= did_read;
      s2_mwrite <= did_write;
      s2_maddr  <= (did_read || did_write) ? {s1_addr[31:2], 2'b00} : 32'd0;
      s2_mdata  <= did_write ? merged : 32'd0;
    end
  end

  logic [31:0] rdata_c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (s2_lane[k].src)
        pmba_pkg::SRC_ROM:    rdata_c[8*k +: 8] = rom_q[s2_lane[k].bank];
        pmba_pkg::SRC_RAM:    rdata_c[8*k +: 8] = ram_q[s2_lane[k].bank];
        pmba_pkg::SRC_DEVICE: rdata_c[8*k +: 8] = s2_lane[k].fixed;
        default:              rdata_c[8*k +: 8] = 8'h00;
      endcase
    end
  end

  // output register
  logic             out_ok;
  pmba_pkg::fault_t out_kind;
  logic [31:0]      out_epc, out_rdata, out_maddr, out_mdata;
  logic             out_mread, out_mwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_ok     <= s2_kind == pmba_pkg::FAULT_NONE;
      out_kind   <= s2_kind;
      out_epc    <= s2_pc;
      out_rdata  <= rdata_c;
      out_mread  <= s2_mread;
      out_mwrite <= s2_mwrite;
      out_maddr  <= s2_maddr;
      out_mdata  <= s2_mdata;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_mdata, out_maddr, out_mwrite, out_mread, out_rdata, out_epc};
  assign m_tuser  = {out_kind, out_ok};

`ifndef SYNTH
  a_clear_after_reset: assert property (@(posedge clk) rst |=> clr_active)
    else $error("clearing pass not started by reset");

  a_ok_matches_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_ok == (out_kind == pmba_pkg::FAULT_NONE)))
    else $error("ok disagrees with fault kind");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_ok) |-> (out_rdata == 32'd0 && !out_mread && !out_mwrite &&
                               out_maddr == 32'd0))
    else $error("faulted word carries data");

  a_mdata_only_on_write: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_mwrite) |-> out_mdata == 32'd0)
    else $error("device data without device write");

  a_rom_write_preload: assert property (@(posedge clk) disable iff (rst)
    (!clr_active && |rom_we) |-> (s1_valid && s1_func == pmba_pkg::FUNC_PRELOAD))
    else $error("rom written by other than preload");
`endif

endmodule

// File: verif/tb_protected_memory_bus_access_top.sv
// testbench for protected_memory_bus_access_top: predicts and checks every result word
module tb_protected_memory_bus_access_top;

  localparam int ROM_DEPTH = 16384;
  localparam int RAM_DEPTH = 65536;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_ODD = 2'd3;
  localparam int PHASE_ITEMS = 320;
  localparam int MAX_PRINTS = 20;

  typedef struct {
    pmba_pkg::func_t func;
    logic [1:0]  size;
    logic [31:0] addr;
    logic        sup;
    logic [31:0] pc;
    logic [31:0] wdata;
    logic        dev_on;
    logic [31:0] dev_word;
  } access_t;

  typedef struct {
    logic        ok;
    logic [1:0]  kind;
    logic [31:0] epc;
    logic [31:0] rdata;
    logic        mrd;
    logic        mwr;
    logic [31:0] maddr;
    logic [31:0] mdata;
  } result_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [pmba_pkg::IN_TDATA_W-1:0] s_tdata;
  logic [pmba_pkg::IN_TUSER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [pmba_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [pmba_pkg::OUT_TUSER_W-1:0] m_tuser;

  // bounds and arrays as the block should hold them
  logic [31:0] bound_rom_start;
  logic [31:0] bound_rom_last;
  logic [31:0] bound_ram_start;
  logic [31:0] bound_ram_last;
  logic [7:0] rom_img [ROM_DEPTH];
  logic [7:0] ram_img [RAM_DEPTH];

  // device word of the access being predicted
  logic dev_on;
  logic [31:0] dev_word;
  logic dev_rd;
  logic dev_wr;
  logic [31:0] dev_addr;

  access_t pending_access[$];
  result_t expected_result[$];
  result_t want;
  access_t seen;
  int errors;
  bit steady;

  protected_memory_bus_access_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic pmba_pkg::area_t area_of(logic [31:0] a);
    if (a <= bound_rom_last) return pmba_pkg::AREA_ROM;
    if (a <= bound_ram_last) return pmba_pkg::AREA_RAM;
    return pmba_pkg::AREA_MMIO;
  endfunction

  function automatic logic [7:0] load_byte(logic [31:0] a);
    logic [31:0] off;
    case (area_of(a))
      pmba_pkg::AREA_ROM: begin
        off = a - bound_rom_start;
        if (off < ROM_DEPTH) return rom_img[off];
        return 8'h00;
      end
      pmba_pkg::AREA_RAM: begin
        off = a - bound_ram_start;
        if (off < RAM_DEPTH) return ram_img[off];
        return 8'h00;
      end
      default: begin
        if (!dev_on) return 8'h00;
        dev_rd = 1'b1;
        dev_addr = {a[31:2], 2'b00};
        return dev_word[a[1:0]*8 +: 8];
      end
    endcase
  endfunction

  function automatic void store_byte(logic [31:0] a, logic [7:0] v);
    logic [31:0] off;
    case (area_of(a))
      pmba_pkg::AREA_ROM: ;
      pmba_pkg::AREA_RAM: begin
        off = a - bound_ram_start;
        if (off < RAM_DEPTH) ram_img[off] = v;
      end
      default: begin
        if (dev_on) begin
          dev_rd = 1'b1;
          dev_wr = 1'b1;
          dev_addr = {a[31:2], 2'b00};
          dev_word[a[1:0]*8 +: 8] = v;
        end
      end
    endcase
  endfunction

  function automatic logic [31:0] load_word(logic [31:0] a);
    logic [7:0] b0, b1, b2, b3;
    b0 = load_byte(a);
    b1 = load_byte(a + 32'd1);
    b2 = load_byte(a + 32'd2);
    b3 = load_byte(a + 32'd3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic result_t predict_access(access_t a);
    result_t r;
    pmba_pkg::fault_t kind;
    logic [31:0] rd;
    logic [7:0] lo, hi;
    logic [31:0] off;
    logic in_mmio;
    logic misaligned;
    dev_on = a.dev_on;
    dev_word = a.dev_word;
    dev_rd = 1'b0;
    dev_wr = 1'b0;
    dev_addr = '0;
    kind = pmba_pkg::FAULT_NONE;
    rd = '0;
    in_mmio = (area_of(a.addr) == pmba_pkg::AREA_MMIO);
    misaligned = (a.size == pmba_pkg::SIZE_HALF && a.addr[0]) ||
                 (a.size >= SIZE_WORD && a.addr[1:0] != 2'b00);
    case (a.func)
      pmba_pkg::FUNC_READ: begin
        if (misaligned) kind = pmba_pkg::FAULT_MEMORY;
        else if (in_mmio && !a.sup) kind = pmba_pkg::FAULT_PRIVILEGE;
        else if (a.size == pmba_pkg::SIZE_BYTE) rd = {24'h0, load_byte(a.addr)};
        else if (a.size == pmba_pkg::SIZE_HALF) begin
          if (in_mmio) begin
            if (dev_on) begin
              dev_rd = 1'b1;
              dev_addr = {a.addr[31:2], 2'b00};
              rd = {16'h0, a.addr[1] ? dev_word[31:16] : dev_word[15:0]};
            end
          end else begin
            lo = load_byte(a.addr);
            hi = load_byte(a.addr + 32'd1);
            rd = {16'h0, hi, lo};
          end
        end else begin
          if (in_mmio) begin
            if (dev_on) begin
              dev_rd = 1'b1;
              dev_addr = a.addr;
              rd = dev_word;
            end
          end else rd = load_word(a.addr);
        end
      end
      pmba_pkg::FUNC_WRITE: begin
        if (misaligned) kind = pmba_pkg::FAULT_MEMORY;
        else if (area_of(a.addr) == pmba_pkg::AREA_ROM) kind = pmba_pkg::FAULT_MEMORY;
        else if (in_mmio && !a.sup) kind = pmba_pkg::FAULT_PRIVILEGE;
        else if (a.size == pmba_pkg::SIZE_BYTE) store_byte(a.addr, a.wdata[7:0]);
        else if (a.size == pmba_pkg::SIZE_HALF) begin
          if (in_mmio) begin
            if (dev_on) begin
              dev_rd = 1'b1;
              dev_wr = 1'b1;
              dev_addr = {a.addr[31:2], 2'b00};
              if (a.addr[1]) dev_word[31:16] = a.wdata[15:0];
              else dev_word[15:0] = a.wdata[15:0];
            end
          end else begin
            store_byte(a.addr, a.wdata[7:0]);
            store_byte(a.addr + 32'd1, a.wdata[15:8]);
          end
        end else begin
          if (in_mmio) begin
            if (dev_on) begin
              dev_wr = 1'b1;
              dev_addr = a.addr;
              dev_word = a.wdata;
            end
          end else begin
            store_byte(a.addr, a.wdata[7:0]);
            store_byte(a.addr + 32'd1, a.wdata[15:8]);
            store_byte(a.addr + 32'd2, a.wdata[23:16]);
            store_byte(a.addr + 32'd3, a.wdata[31:24]);
          end
        end
      end
      pmba_pkg::FUNC_FETCH: begin
        if (a.addr[1:0] != 2'b00 || in_mmio) kind = pmba_pkg::FAULT_MEMORY;
        else rd = load_word(a.addr);
      end
      default: begin
        case (area_of(a.addr))
          pmba_pkg::AREA_ROM: begin
            off = a.addr - bound_rom_start;
            if (off < ROM_DEPTH) rom_img[off] = a.wdata[7:0];
          end
          pmba_pkg::AREA_RAM: begin
            off = a.addr - bound_ram_start;
            if (off < RAM_DEPTH) ram_img[off] = a.wdata[7:0];
          end
          default: ;
        endcase
      end
    endcase
    r.ok = (kind == pmba_pkg::FAULT_NONE);
    r.kind = kind;
    r.epc = (kind != pmba_pkg::FAULT_NONE) ? a.pc : 32'h0;
    r.rdata = rd;
    r.mrd = dev_rd;
    r.mwr = dev_wr;
    r.maddr = (dev_rd || dev_wr) ? dev_addr : 32'h0;
    r.mdata = dev_wr ? dev_word : 32'h0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (errors < MAX_PRINTS)
      $display("mismatch in %s: got %h, expected %h", what, got, exp_val);
    errors++;
  endtask

  // access source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_access.size() > 0 && (steady || $urandom_range(0, 99) >= 29)) begin
        seen = pending_access.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= seen.func;
        s_tdata <= {4'b0, seen.dev_word, seen.dev_on, seen.wdata, seen.pc,
                    seen.sup, seen.addr, seen.size};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // predict on every accepted access word
  always @(posedge clk) begin : access_mon
    access_t a;
    if (!rst && s_tvalid && s_tready) begin
      a.func = pmba_pkg::func_t'(s_tuser[1:0]);
      a.size = s_tdata[1:0];
      a.addr = s_tdata[33:2];
      a.sup = s_tdata[34];
      a.pc = s_tdata[66:35];
      a.wdata = s_tdata[98:67];
      a.dev_on = s_tdata[99];
      a.dev_word = s_tdata[131:100];
      expected_result.push_back(predict_access(a));
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_result.size() == 0) begin
          report_mismatch("unexpected result word", m_tdata[31:0], 32'h0);
        end else begin
          want = expected_result.pop_front();
          if (m_tuser[0] !== want.ok) report_mismatch("ok", m_tuser[0], want.ok);
          if (m_tuser[2:1] !== want.kind) report_mismatch("fault_kind", m_tuser[2:1], want.kind);
          if (m_tdata[31:0] !== want.epc) report_mismatch("fault_epc", m_tdata[31:0], want.epc);
          if (m_tdata[63:32] !== want.rdata)
            report_mismatch("read_data", m_tdata[63:32], want.rdata);
          if (m_tdata[64] !== want.mrd) report_mismatch("mmio_read", m_tdata[64], want.mrd);
          if (m_tdata[65] !== want.mwr) report_mismatch("mmio_write", m_tdata[65], want.mwr);
          if (m_tdata[97:66] !== want.maddr)
            report_mismatch("mmio_address", m_tdata[97:66], want.maddr);
          if (m_tdata[129:98] !== want.mdata)
            report_mismatch("mmio_data", m_tdata[129:98], want.mdata);
        end
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  task automatic add_access(pmba_pkg::func_t f, logic [1:0] sz, logic [31:0] ad, logic sup,
                            logic dev, logic [31:0] dw, logic [31:0] wd);
    access_t a;
    a.func = f;
    a.size = sz;
    a.addr = ad;
    a.sup = sup;
    a.pc = $urandom;
    a.wdata = wd;
    a.dev_on = dev;
    a.dev_word = dw;
    pending_access.push_back(a);
  endtask

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 10))
      0: return bound_rom_start + $urandom_range(0, 15);
      1: return bound_rom_last - 32'd3 + $urandom_range(0, 7);
      2: return bound_ram_start + $urandom_range(0, 31);
      3: return bound_ram_start + $urandom_range(0, 31);
      4: return bound_ram_last - 32'd3 + $urandom_range(0, 7);
      5: return bound_rom_start + ROM_DEPTH - 32'd4 + $urandom_range(0, 7);
      6: return bound_ram_start + RAM_DEPTH - 32'd4 + $urandom_range(0, 7);
      7: return $urandom;
      8: return 32'hFFFF_FFF8 + $urandom_range(0, 7);
      9: return $urandom_range(0, 15);
      default: return bound_ram_last + 32'd1 + $urandom_range(0, 63);
    endcase
  endfunction

  task automatic add_random_accesses(int n);
    pmba_pkg::func_t f;
    logic [1:0] sz;
    logic [31:0] ad;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) f = pmba_pkg::FUNC_READ;
      else if (pick < 55) f = pmba_pkg::FUNC_WRITE;
      else if (pick < 70) f = pmba_pkg::FUNC_FETCH;
      else f = pmba_pkg::FUNC_PRELOAD;
      sz = ($urandom_range(0, 99) < 6) ? SIZE_ODD : 2'($urandom_range(0, 2));
      ad = pick_address();
      if ($urandom_range(0, 99) < 75) begin
        if (sz == pmba_pkg::SIZE_HALF) ad[0] = 1'b0;
        else if (sz != pmba_pkg::SIZE_BYTE || f == pmba_pkg::FUNC_FETCH) ad[1:0] = 2'b00;
      end
      add_access(f, sz, ad, $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 80,
                 $urandom, $urandom);
      // read back what was just stored or preloaded
      if ((f == pmba_pkg::FUNC_WRITE || f == pmba_pkg::FUNC_PRELOAD) &&
          $urandom_range(0, 99) < 45) begin
        i++;
        add_access($urandom_range(0, 3) == 0 ? pmba_pkg::FUNC_FETCH : pmba_pkg::FUNC_READ,
                   2'($urandom_range(0, 2)), ad, 1'b1, $urandom_range(0, 99) < 80,
                   $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_access.size() != 0 || s_tvalid || expected_result.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_bounds(logic [31:0] rb, logic [31:0] rl, logic [31:0] ab,
                            logic [31:0] al);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= pmba_pkg::CFG_ROM_START;
    cfg_data <= rb;
    @(posedge clk);
    cfg_index <= pmba_pkg::CFG_ROM_LAST;
    cfg_data <= rl;
    @(posedge clk);
    cfg_index <= pmba_pkg::CFG_RAM_START;
    cfg_data <= ab;
    @(posedge clk);
    cfg_index <= pmba_pkg::CFG_RAM_LAST;
    cfg_data <= al;
    @(posedge clk);
    cfg_write <= 1'b0;
    bound_rom_start = rb;
    bound_rom_last = rl;
    bound_ram_start = ab;
    bound_ram_last = al;
  endtask

  initial begin
    logic [31:0] rb, rl, ab;
    errors = 0;
    steady = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = pmba_pkg::CFG_ROM_START;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    bound_rom_start = pmba_pkg::ROM_START_RESET;
    bound_rom_last = pmba_pkg::ROM_LAST_RESET;
    bound_ram_start = pmba_pkg::RAM_START_RESET;
    bound_ram_last = pmba_pkg::RAM_LAST_RESET;
    foreach (rom_img[i]) rom_img[i] = 8'h00;
    foreach (ram_img[i]) ram_img[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset bounds: rom below 0x4000, ram up to 0x13fff, mmio above
    add_access(pmba_pkg::FUNC_PRELOAD, pmba_pkg::SIZE_BYTE, 32'h0, 1'b0, 1'b0, 32'h0,
               32'h0000_00A5);
    add_access(pmba_pkg::FUNC_PRELOAD, SIZE_WORD, 32'h1, 1'b0, 1'b1, $urandom,
               32'hFFFF_FF3C);
    add_access(pmba_pkg::FUNC_PRELOAD, pmba_pkg::SIZE_HALF, 32'h2, 1'b1, 1'b0, 32'h0,
               32'h0000_00FF);
    add_access(pmba_pkg::FUNC_PRELOAD, SIZE_ODD, 32'h3, 1'b0, 1'b0, 32'h0,
               32'h1234_5681);
    add_access(pmba_pkg::FUNC_PRELOAD, pmba_pkg::SIZE_BYTE, 32'h4000, 1'b0, 1'b0, 32'h0,
               32'h0000_005A);
    add_access(pmba_pkg::FUNC_PRELOAD, pmba_pkg::SIZE_BYTE, 32'h1_4000, 1'b1, 1'b1,
               32'hFFFF_FFFF, 32'hFF);
    add_access(pmba_pkg::FUNC_READ, SIZE_WORD, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_FETCH, pmba_pkg::SIZE_BYTE, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_READ, pmba_pkg::SIZE_HALF, 32'h2, 1'b0, 1'b0, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_READ, SIZE_ODD, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_WRITE, SIZE_WORD, 32'h4004, 1'b0, 1'b0, 32'h0,
               32'hFFFF_FFFF);
    add_access(pmba_pkg::FUNC_READ, SIZE_WORD, 32'h4004, 1'b0, 1'b0, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_WRITE, pmba_pkg::SIZE_HALF, 32'h4005, 1'b1, 1'b0, 32'h0,
               32'h1111);
    add_access(pmba_pkg::FUNC_WRITE, pmba_pkg::SIZE_BYTE, 32'h10, 1'b1, 1'b0, 32'h0,
               32'h22);
    add_access(pmba_pkg::FUNC_READ, SIZE_WORD, 32'h4002, 1'b1, 1'b0, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_READ, SIZE_WORD, 32'h1_4000, 1'b0, 1'b1, 32'hDEAD_BEEF,
               32'h0);
    add_access(pmba_pkg::FUNC_READ, SIZE_WORD, 32'h1_4000, 1'b1, 1'b1, 32'hDEAD_BEEF,
               32'h0);
    add_access(pmba_pkg::FUNC_READ, pmba_pkg::SIZE_HALF, 32'h1_4002, 1'b1, 1'b1,
               32'hCAFE_F00D, 32'h0);
    add_access(pmba_pkg::FUNC_READ, pmba_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 1'b1, 1'b0,
               32'hFFFF_FFFF, 32'h0);
    add_access(pmba_pkg::FUNC_WRITE, pmba_pkg::SIZE_BYTE, 32'h1_4001, 1'b1, 1'b1,
               32'h1234_5678, 32'h0000_00AB);
    add_access(pmba_pkg::FUNC_WRITE, pmba_pkg::SIZE_HALF, 32'h1_4002, 1'b1, 1'b1,
               32'h1234_5678, 32'h0000_BEEF);
    add_access(pmba_pkg::FUNC_WRITE, SIZE_WORD, 32'h1_4004, 1'b1, 1'b1, 32'hFFFF_FFFF,
               32'h0);
    add_access(pmba_pkg::FUNC_WRITE, SIZE_WORD, 32'h1_4008, 1'b1, 1'b0, 32'h5555_5555,
               32'hAAAA_AAAA);
    add_access(pmba_pkg::FUNC_FETCH, SIZE_WORD, 32'h1_4000, 1'b1, 1'b1, 32'h0, 32'h0);
    add_access(pmba_pkg::FUNC_FETCH, SIZE_WORD, 32'h4002, 1'b1, 1'b0, 32'h0, 32'h0);
    add_random_accesses(PHASE_ITEMS);
    wait_drained();

    set_bounds(32'h0000_0100, 32'h0000_20FF, 32'h0000_3000, 32'h0001_2FFF);
    add_random_accesses(PHASE_ITEMS);
    wait_drained();

    // extremes: only address 0 is rom, everything else ram; the rom start above it wraps the rom offset
    set_bounds(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    steady = 1'b1;
    add_random_accesses(PHASE_ITEMS);
    wait_drained();
    steady = 1'b0;

    // everything decodes as rom
    set_bounds(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_random_accesses(PHASE_ITEMS);
    wait_drained();

    set_bounds(32'h1000_0000, 32'h1000_3FFF, 32'h1000_4000, 32'h1001_3FFF);
    add_random_accesses(PHASE_ITEMS);
    wait_drained();

    rb = $urandom;
    rl = rb + $urandom_range(100, 20000);
    ab = rl + 32'd1 - $urandom_range(0, 3);
    set_bounds(rb, rl, ab, ab + $urandom_range(100, 70000));
    add_random_accesses(PHASE_ITEMS);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
